// File: sv/fwkp_pkg.sv
package fwkp_pkg;

   // Queue geometry
   localparam int DEPTH = 16;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   // Field widths
   localparam int OP_W     = 2;
   localparam int KEY_W    = 16;
   localparam int CAT_W    = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Command queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Command op codes as they arrive on the bus
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
   localparam logic [OP_W-1:0] OP_POP     = 2'd1;
   localparam logic [OP_W-1:0] OP_PROMOTE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef enum logic [1:0] {
      CMD_PUSH,
      CMD_POP,
      CMD_PROMOTE,
      CMD_NOP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [KEY_W-1:0] key;
      logic [CAT_W-1:0] cat;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_POP,
      BK_SCAN,
      BK_RESTORE,
      BK_REPLY
   } back_state_type;

endpackage

// File: sv/fwkp_front.sv
module fwkp_front
   import fwkp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic [OP_W-1:0]     req_tuser,
   output logic                cmd_valid,
   output cmd_type             cmd,
   input  logic                cmd_take
);

   cmd_type             q_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   level_ff, level_in;
   cmd_type             cmd_dec;
   logic                accept;

   // classify the incoming transaction
   always_comb begin
      cmd_dec.key = req_tdata[KEY_W-1:0];
      cmd_dec.cat = req_tdata[KEY_W+CAT_W-1:KEY_W];
      unique case (req_tuser)
         OP_PUSH:    cmd_dec.kind = CMD_PUSH;
         OP_POP:     cmd_dec.kind = CMD_POP;
         OP_PROMOTE: cmd_dec.kind = CMD_PROMOTE;
         default:    cmd_dec.kind = CMD_NOP;
      endcase
   end

   assign req_tready = (level_ff != QCNT_W'(QDEPTH));
   assign accept     = req_tvalid && req_tready;
   assign cmd_valid  = (level_ff != '0);
   assign cmd        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_take) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !cmd_take) begin
         level_in = level_ff + 1'b1;
      end else if (!accept && cmd_take) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         q_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

endmodule

// File: sv/fwkp_back.sv
module fwkp_back
   import fwkp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_take,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,
   output logic [STATUS_W-1:0] rsp_tuser
);

   // circular add, offset at most DEPTH
   function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [CNT_W-1:0] off);
      logic [CNT_W:0] s;
      s = (CNT_W+1)'(ptr) + (CNT_W+1)'(off);
      if (s >= (CNT_W+1)'(DEPTH)) begin
         s = s - (CNT_W+1)'(DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   // entry store (circular) and promote scratch store
   logic [KEY_W-1:0] main_key_mem [DEPTH];
   logic [CAT_W-1:0] main_cat_mem [DEPTH];
   logic [KEY_W-1:0] tmp_key_mem  [DEPTH];
   logic [CAT_W-1:0] tmp_cat_mem  [DEPTH];

   back_state_type   state_ff, state_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] scan_ff, scan_in;
   logic             pend_ff, pend_in;
   logic [CNT_W-1:0] m_ff, m_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] rw_ff, rw_in;
   logic [KEY_W-1:0] pkey_ff, pkey_in;
   logic [KEY_W-1:0] main_rd_key_ff, tmp_rd_key_ff;
   logic [CAT_W-1:0] main_rd_cat_ff, tmp_rd_cat_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [KEY_W-1:0]    rsp_code_ff;
   logic [CAT_W-1:0]    rsp_cat_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic                out_free;
   logic                emit;
   logic [STATUS_W-1:0] res_status;
   logic [KEY_W-1:0]    res_code;
   logic [CAT_W-1:0]    res_cat;
   logic [PTR_W-1:0]    tail;
   logic [PTR_W-1:0]    new_head;
   logic [PTR_W-1:0]    rd_addr, tmp_rd_addr;
   logic                main_we, tmp_we;
   logic [PTR_W-1:0]    main_wa, tmp_wa;
   logic [KEY_W-1:0]    main_wkey;
   logic [CAT_W-1:0]    main_wcat;
   logic                scan_done, restore_done;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign tail         = wrap_add(head_ff, count_ff);
   assign new_head     = wrap_add(head_ff, CNT_W'(DEPTH) - m_ff);
   assign scan_done    = !pend_ff && (scan_ff == count_ff);
   assign restore_done = !pend_ff && (scan_ff == m_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               if (cmd.kind == CMD_POP && count_ff != '0) begin
                  state_in = BK_POP;
               end else if (cmd.kind == CMD_PROMOTE && count_ff != '0) begin
                  state_in = BK_SCAN;
               end
            end
         end
         BK_POP: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         BK_SCAN: begin
            if (scan_done) begin
               state_in = BK_RESTORE;
            end
         end
         BK_RESTORE: begin
            if (restore_done) begin
               state_in = BK_REPLY;
            end
         end
         BK_REPLY: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      cmd_take    = 1'b0;
      emit        = 1'b0;
      res_status  = ST_OK;
      res_code    = '0;
      res_cat     = '0;
      head_in     = head_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      pend_in     = 1'b0;
      m_in        = m_ff;
      k_in        = k_ff;
      rw_in       = rw_ff;
      pkey_in     = pkey_ff;
      rd_addr     = head_ff;
      tmp_rd_addr = scan_ff[PTR_W-1:0];
      main_we     = 1'b0;
      main_wa     = tail;
      main_wkey   = cmd.key;
      main_wcat   = cmd.cat;
      tmp_we      = 1'b0;
      tmp_wa      = m_ff[PTR_W-1:0];
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  CMD_PUSH: begin
                     if (out_free) begin
                        cmd_take = 1'b1;
                        emit     = 1'b1;
                        if (count_ff == CNT_W'(DEPTH)) begin
                           res_status = ST_FULL;
                        end else begin
                           main_we  = 1'b1;
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  CMD_POP: begin
                     if (count_ff != '0) begin
                        // head read issued now, data valid in BK_POP
                        cmd_take = 1'b1;
                     end else if (out_free) begin
                        cmd_take   = 1'b1;
                        emit       = 1'b1;
                        res_status = ST_EMPTY;
                     end
                  end
                  CMD_PROMOTE: begin
                     if (count_ff != '0) begin
                        cmd_take = 1'b1;
                        pkey_in  = cmd.key;
                        scan_in  = '0;
                        m_in     = '0;
                        k_in     = '0;
                     end else if (out_free) begin
                        cmd_take = 1'b1;
                        emit     = 1'b1;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        cmd_take = 1'b1;
                        emit     = 1'b1;
                     end
                  end
               endcase
            end
         end
         BK_POP: begin
            if (out_free) begin
               emit     = 1'b1;
               res_code = main_rd_key_ff;
               res_cat  = main_rd_cat_ff;
               head_in  = wrap_add(head_ff, CNT_W'(1));
               count_in = count_ff - 1'b1;
            end
         end
         BK_SCAN: begin
            // read entry scan_ff, sort the one read last cycle
            rd_addr = wrap_add(head_ff, scan_ff);
            if (scan_ff != count_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               if (main_rd_key_ff == pkey_ff) begin
                  tmp_we = 1'b1;
                  m_in   = m_ff + 1'b1;
               end else begin
                  main_we   = 1'b1;
                  main_wa   = wrap_add(head_ff, k_ff);
                  main_wkey = main_rd_key_ff;
                  main_wcat = main_rd_cat_ff;
                  k_in      = k_ff + 1'b1;
               end
            end
            if (scan_done) begin
               scan_in = '0;
               rw_in   = '0;
            end
         end
         BK_RESTORE: begin
            // copy matches into the slots just ahead of the head
            if (scan_ff != m_ff) begin
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
            if (pend_ff) begin
               main_we   = 1'b1;
               main_wa   = wrap_add(new_head, rw_ff);
               main_wkey = tmp_rd_key_ff;
               main_wcat = tmp_rd_cat_ff;
               rw_in     = rw_ff + 1'b1;
            end
            if (restore_done) begin
               head_in = new_head;
            end
         end
         BK_REPLY: begin
            if (out_free) begin
               emit = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
      rw_ff   <= rw_in;
      pkey_ff <= pkey_in;
      if (emit) begin
         rsp_status_ff <= res_status;
         rsp_code_ff   <= res_code;
         rsp_cat_ff    <= res_cat;
         rsp_count_ff  <= COUNT_W'(count_in);
      end
   end

   // memories: one write port, registered read
   always_ff @(posedge clock) begin
      if (main_we) begin
         main_key_mem[main_wa] <= main_wkey;
         main_cat_mem[main_wa] <= main_wcat;
      end
      main_rd_key_ff <= main_key_mem[rd_addr];
      main_rd_cat_ff <= main_cat_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (tmp_we) begin
         tmp_key_mem[tmp_wa] <= main_rd_key_ff;
         tmp_cat_mem[tmp_wa] <= main_rd_cat_ff;
      end
      tmp_rd_key_ff <= tmp_key_mem[tmp_rd_addr];
      tmp_rd_cat_ff <= tmp_cat_mem[tmp_rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(32 - KEY_W - CAT_W - COUNT_W){1'b0}},
                        rsp_count_ff, rsp_cat_ff, rsp_code_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count above capacity");

   a_scan_split: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_SCAN |-> (m_ff + k_ff + CNT_W'(pend_ff)) == scan_ff)
      else $error("promote scan lost or duplicated an entry");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |-> state_ff == BK_IDLE)
      else $error("command taken while busy");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("result not presented");

   a_no_emit_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !emit)
      else $error("result overwritten while stalled");

endmodule

// File: sv/fifo_with_key_promotion.sv
// Channel | Direction | Payload
// req_*   | in        | tuser[1:0] op; tdata[15:0] key_code, [23:16] category
// rsp_*   | out       | tuser[1:0] status; tdata[15:0] out_code, [23:16] out_category,
//         |           |   [28:24] count
//
// Push, failed pop, no-op and promote on an empty queue finish in the back
// end's idle state; pop adds a registered entry store read (BK_POP). Promote
// of n stored entries with m matches makes one entry store pass (BK_SCAN)
// and one scratch copy pass (BK_RESTORE), then replies (BK_REPLY).
// The front registers each command and queues two commands.
// Reset clears the count, pointers and handshake state; stored entries stay.
// A stalled rsp side holds the result register; the back end waits, the
// command queue fills, then req_tready drops.
module fifo_with_key_promotion
   import fwkp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // key_code[15:0], category[23:16]
   input  logic [OP_W-1:0]     req_tuser,   // op[1:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // out_code[15:0], out_category[23:16],
                                            // count[28:24], zero pad
   output logic [STATUS_W-1:0] rsp_tuser    // status[1:0]
);

   // front -> back command transaction
   logic    cmd_valid;
   logic    cmd_take;
   cmd_type cmd;

   fwkp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take)
   );

   // back end owns the entry store and the result register
   fwkp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_take   (cmd_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
